@@ rtl/framed_packet_crc_checker_defines.svh @@
// Assertion helpers shared by the checker modules.
// Every helper samples on the rising edge of clk and is off while rst is high.
`ifndef FRAMED_PACKET_CRC_CHECKER_DEFINES_SVH
`define FRAMED_PACKET_CRC_CHECKER_DEFINES_SVH

// The expression holds at every clock edge.
`define FPCC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the trigger holds, the consequence holds at the same edge.
`define FPCC_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// When the trigger holds, the consequence holds at the next edge.
`define FPCC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fpcc_pkg.sv @@
package fpcc_pkg;

  // Largest number of bytes counted in one frame; later bytes are dropped.
  localparam int MAX_FRAME_BYTES = 1024;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SPAN_W = 17;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [SPAN_W-1:0] HEADER_EXTRA = SPAN_W'(10);

  localparam logic [7:0] START_CODE_RESET = 8'h5A;
  localparam logic [7:0] END_CODE_RESET = 8'h77;

  // Configuration register indexes.
  localparam logic CFG_START_CODE = 1'b0;
  localparam logic CFG_END_CODE = 1'b1;

  // Verdict codes.
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_END = 3'd2;
  localparam logic [2:0] ST_SHORT = 3'd3;
  localparam logic [2:0] ST_CRC = 3'd4;

  localparam int RES_W = 76;
  localparam int TDATA_OUT_W = 80;

  typedef struct packed {
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [15:0] body_length;
    logic [7:0]  serial_byte;
    logic [7:0]  flag_byte;
    logic [7:0]  mode_byte;
    logic [2:0]  status;
    logic        frame_ok;
  } result_t;

  // One byte of CRC-16/MODBUS, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/framed_packet_crc_checker.sv @@
// The final byte of a frame passes the input register and then the result register before its
// verdict is on m_tvalid; a full result register can stall it in between.
// Throughput: one byte per cycle; only a final byte waits, and only while an earlier
// result in the result register has not yet been taken.
// Reset (rst, synchronous, active high) empties both registers, clears the frame state and
// restores start_code to 0x5A and end_code to 0x77.
module framed_packet_crc_checker
  import fpcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Frame bytes. s_tdata: data_byte [7:0]. s_tlast marks the final byte of the frame.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tlast,
  // Verdicts. m_tdata: frame_ok [0], status [3:1], mode_byte [11:4], flag_byte [19:12],
  // serial_byte [27:20], body_length [43:28], received_crc [59:44],
  // computed_crc [75:60], zero [79:76].
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  // Configuration writes: index 0 is start_code, index 1 is end_code.
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data
);

  logic [7:0] start_code;
  logic [7:0] end_code;

  // Input register: holds one byte request until the frame logic consumes it.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic    proc;
  logic    out_free;
  logic    res_valid;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RESET;
      end_code <= END_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CODE: start_code <= cfg_data;
        CFG_END_CODE:   end_code <= cfg_data;
        default:        ;
      endcase
    end
  end

  // A plain byte is always consumed; a final byte needs room in the result register.
  assign proc = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Per-frame field capture, CRC and verdict.
  fpcc_frame_track u_track (
    .clk        (clk),
    .rst        (rst),
    .proc       (proc),
    .data_byte  (in_byte),
    .last_byte  (in_last),
    .start_code (start_code),
    .end_code   (end_code),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register, which lets new byte requests flow while a verdict waits.
  fpcc_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ rtl/fpcc_frame_track.sv @@
`include "framed_packet_crc_checker_defines.svh"

module fpcc_frame_track
  import fpcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       proc,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] start_code,
  input  logic [7:0] end_code,
  output logic       res_valid,
  output result_t    res
);

  logic [CNT_W-1:0] byte_count;
  logic [15:0]      running_crc;
  logic [15:0]      length_field;
  logic [15:0]      checksum_field;
  logic [7:0]       first_byte;
  logic [7:0]       mode_field;
  logic [7:0]       flag_field;
  logic [7:0]       serial_field;
  logic [15:0]      crc_frozen;

  logic [CNT_W-1:0] byte_count_next;
  logic [15:0]      running_crc_next;
  logic [15:0]      length_field_next;
  logic [15:0]      checksum_field_next;
  logic [7:0]       first_byte_next;
  logic [7:0]       mode_field_next;
  logic [7:0]       flag_field_next;
  logic [7:0]       serial_field_next;
  logic [15:0]      crc_frozen_next;

  logic              in_range;
  logic              covered;
  logic [SPAN_W-1:0] span;
  logic [15:0]       crc_step;
  logic [7:0]        crc_data;
  logic [2:0]        status;

  assign in_range = byte_count < CNT_W'(MAX_FRAME_BYTES);

  always_comb begin
    first_byte_next = (in_range && byte_count == CNT_W'(0)) ? data_byte : first_byte;
    mode_field_next = (in_range && byte_count == CNT_W'(1)) ? data_byte : mode_field;
    length_field_next[15:8] = (in_range && byte_count == CNT_W'(2)) ? data_byte
                                                                     : length_field[15:8];
    length_field_next[7:0] = (in_range && byte_count == CNT_W'(3)) ? data_byte
                                                                    : length_field[7:0];
    flag_field_next = (in_range && byte_count == CNT_W'(4)) ? data_byte : flag_field;
    checksum_field_next[15:8] = (in_range && byte_count == CNT_W'(5)) ? data_byte
                                                                       : checksum_field[15:8];
    checksum_field_next[7:0] = (in_range && byte_count == CNT_W'(6)) ? data_byte
                                                                      : checksum_field[7:0];
    serial_field_next = (in_range && byte_count == CNT_W'(7)) ? data_byte : serial_field;
  end

  // The checksum bytes themselves enter the CRC as zero.
  assign crc_data = (byte_count == CNT_W'(5) || byte_count == CNT_W'(6)) ? 8'h00 : data_byte;
  assign crc_step = crc_byte(running_crc, crc_data);
  assign span = {1'b0, length_field_next} + HEADER_EXTRA;
  assign covered = in_range && (SPAN_W'(byte_count) < span);

  assign running_crc_next = covered ? crc_step : running_crc;
  assign crc_frozen_next = covered ? crc_step : crc_frozen;
  assign byte_count_next = in_range ? byte_count + CNT_W'(1) : byte_count;

  always_comb begin
    priority if (first_byte_next != start_code) begin
      status = ST_BAD_START;
    end else if (data_byte != end_code) begin
      status = ST_BAD_END;
    end else if (SPAN_W'(byte_count_next) < span) begin
      status = ST_SHORT;
    end else if (crc_frozen_next != checksum_field_next) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  assign res_valid = proc && last_byte;
  assign res.frame_ok = (status == ST_OK);
  assign res.status = status;
  assign res.mode_byte = mode_field_next;
  assign res.flag_byte = flag_field_next;
  assign res.serial_byte = serial_field_next;
  assign res.body_length = length_field_next;
  assign res.received_crc = checksum_field_next;
  assign res.computed_crc = crc_frozen_next;

  always_ff @(posedge clk) begin
    if (rst || (proc && last_byte)) begin
      byte_count <= '0;
      running_crc <= CRC_INIT;
      length_field <= '0;
      checksum_field <= '0;
      first_byte <= '0;
      mode_field <= '0;
      flag_field <= '0;
      serial_field <= '0;
      crc_frozen <= '0;
    end else if (proc) begin
      byte_count <= byte_count_next;
      running_crc <= running_crc_next;
      length_field <= length_field_next;
      checksum_field <= checksum_field_next;
      first_byte <= first_byte_next;
      mode_field <= mode_field_next;
      flag_field <= flag_field_next;
      serial_field <= serial_field_next;
      crc_frozen <= crc_frozen_next;
    end
  end

  `FPCC_ASSERT_ALWAYS(a_count_bound, byte_count <= CNT_W'(MAX_FRAME_BYTES), "byte count overran")
  `FPCC_ASSERT_NEXT(a_clear_after_last, proc && last_byte, byte_count == '0 && running_crc == CRC_INIT, "frame state not cleared")
  `FPCC_ASSERT_IMPL(a_ok_needs_length, res_valid && res.frame_ok, SPAN_W'(byte_count_next) >= span, "ok verdict on short frame")

endmodule

@@ rtl/fpcc_result_reg.sv @@
`include "framed_packet_crc_checker_defines.svh"

module fpcc_result_reg
  import fpcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  result_t                res,
  output logic                   out_free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata
);

  result_t held;

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata = {{(TDATA_OUT_W - RES_W){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  `FPCC_ASSERT_IMPL(a_no_overwrite, load, out_free, "result overwritten before it was taken")
  `FPCC_ASSERT_IMPL(a_ok_matches_status, m_tvalid, held.frame_ok == (held.status == ST_OK), "frame_ok disagrees with status")

endmodule

@@ verif/framed_packet_crc_checker_test.sv @@
`timescale 1ns / 1ps

module framed_packet_crc_checker_test;
  import fpcc_pkg::*;

  // A correct run ends well before this limit.
  localparam int LIMIT_CYCLES = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  wire                    s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   s_tlast = 1'b0;
  wire                    m_tvalid;
  logic                   m_tready = 1'b0;
  wire  [TDATA_OUT_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = CFG_START_CODE;
  logic [7:0]             cfg_data = 8'h00;

  framed_packet_crc_checker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Shadow of the checker's frame state and code registers. The input monitor
  // advances it on every accepted request and queues one verdict per frame.
  logic [7:0]  start_code_now;
  logic [7:0]  end_code_now;
  int unsigned seen_count;
  logic [15:0] crc_run;
  logic [15:0] crc_hold;
  logic [15:0] len_fld;
  logic [15:0] chk_fld;
  logic [7:0]  hdr_start;
  logic [7:0]  hdr_mode;
  logic [7:0]  hdr_flag;
  logic [7:0]  hdr_serial;
  result_t     pending_verdicts[$];

  // Frame under construction by the stimulus tasks.
  logic [7:0]  frame_buf[$];

  // When set, neither side inserts idle cycles.
  bit          calm = 1'b0;
  // A test asks for a receiver hold-off here; the ready process counts it down.
  int          hold_req = 0;
  int          hold_left = 0;
  int          longest_hold = 0;

  int          mismatches = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          bytes_accepted = 0;
  int          stall_cycles = 0;
  int          code_writes = 0;
  int          verdict_seen[0:7];

  // One byte of CRC-16/MODBUS, fed bit by bit from the least significant end.
  function automatic logic [15:0] modbus_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void clear_tracking();
    seen_count = 0;
    crc_run    = CRC_INIT;
    crc_hold   = 16'h0000;
    len_fld    = 16'h0000;
    chk_fld    = 16'h0000;
    hdr_start  = 8'h00;
    hdr_mode   = 8'h00;
    hdr_flag   = 8'h00;
    hdr_serial = 8'h00;
  endfunction

  // Advances the shadow state by one frame byte and, on the final byte,
  // queues the verdict the checker has to deliver.
  function automatic void track_byte(input logic [7:0] b, input logic last);
    int unsigned idx;
    int unsigned span;
    result_t     v;
    idx = seen_count;
    // Once the counter saturates, bytes are neither captured nor summed.
    if (idx < MAX_FRAME_BYTES) begin
      case (idx)
        0: hdr_start = b;
        1: hdr_mode = b;
        2: len_fld[15:8] = b;
        3: len_fld[7:0] = b;
        4: hdr_flag = b;
        5: chk_fld[15:8] = b;
        6: chk_fld[7:0] = b;
        7: hdr_serial = b;
        default: ;
      endcase
      span = len_fld + HEADER_EXTRA;
      // The checksum bytes themselves are summed as zero.
      if (idx < span) begin
        crc_run  = modbus_step(crc_run, (idx == 5 || idx == 6) ? 8'h00 : b);
        crc_hold = crc_run;
      end
      seen_count = idx + 1;
    end
    if (last) begin
      span = len_fld + HEADER_EXTRA;
      // Bad start outranks bad end, which outranks short, which outranks CRC.
      if (hdr_start != start_code_now) begin
        v.status = ST_BAD_START;
      end else if (b != end_code_now) begin
        v.status = ST_BAD_END;
      end else if (seen_count < span) begin
        v.status = ST_SHORT;
      end else if (crc_hold != chk_fld) begin
        v.status = ST_CRC;
      end else begin
        v.status = ST_OK;
      end
      v.frame_ok     = (v.status == ST_OK);
      v.mode_byte    = hdr_mode;
      v.flag_byte    = hdr_flag;
      v.serial_byte  = hdr_serial;
      v.body_length  = len_fld;
      v.received_crc = chk_fld;
      v.computed_crc = crc_hold;
      pending_verdicts.push_back(v);
      clear_tracking();
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at cycle %0d", what, got, want, cycle_count);
  endtask

  // Input monitor: every accepted request feeds the shadow model. Values are
  // read at the edge itself, before any register of this edge has updated.
  always @(posedge clk) begin
    if (!rst && s_tvalid) begin
      if (s_tready) begin
        track_byte(s_tdata, s_tlast);
        bytes_accepted++;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Result checker: each delivered verdict is matched against the oldest one queued.
  always @(posedge clk) begin : verdict_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RES_W-1:0]);
      if (m_tdata[TDATA_OUT_W-1:RES_W] !== '0) begin
        report_mismatch("tdata padding", m_tdata[TDATA_OUT_W-1:RES_W], 0);
      end
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict with none pending", got.status, 0);
      end else begin
        want = pending_verdicts.pop_front();
        verdict_seen[want.status]++;
        if (got.frame_ok !== want.frame_ok) begin
          report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
        end
        if (got.status !== want.status) begin
          report_mismatch("status", got.status, want.status);
        end
        if (got.mode_byte !== want.mode_byte) begin
          report_mismatch("mode_byte", got.mode_byte, want.mode_byte);
        end
        if (got.flag_byte !== want.flag_byte) begin
          report_mismatch("flag_byte", got.flag_byte, want.flag_byte);
        end
        if (got.serial_byte !== want.serial_byte) begin
          report_mismatch("serial_byte", got.serial_byte, want.serial_byte);
        end
        if (got.body_length !== want.body_length) begin
          report_mismatch("body_length", got.body_length, want.body_length);
        end
        if (got.received_crc !== want.received_crc) begin
          report_mismatch("received_crc", got.received_crc, want.received_crc);
        end
        if (got.computed_crc !== want.computed_crc) begin
          report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
        end
      end
    end
  end

  // Receiver: ready drops in about a third of the cycles, never while calm,
  // and stays low for the whole of a requested hold-off.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      if (hold_req > longest_hold) begin
        longest_hold = hold_req;
      end
      hold_req = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d verdicts pending", cycle_count,
               pending_verdicts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one byte and returns at the edge where it is accepted. Valid stays
  // high afterwards, so back-to-back bytes need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Drops valid, waits for every queued verdict, then lets the pipeline empty.
  // A non-final byte leaves nothing queued, so the extra cycles cover it too.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_code(input logic idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START_CODE) begin
      start_code_now = val;
    end else begin
      end_code_now = val;
    end
    code_writes++;
  endtask

  // Builds a frame of total bytes whose length field is len. Each flag either
  // makes that part right for the current codes or deliberately wrong. A
  // negative fill gives random bytes, otherwise every free byte takes that value.
  function automatic void build_frame(input int unsigned len, input int unsigned total,
                                      input bit ok_start, input bit ok_end,
                                      input bit ok_crc, input int fill);
    int unsigned covered;
    logic [15:0] acc;
    frame_buf.delete();
    for (int unsigned i = 0; i < total; i++) begin
      frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    end
    if (total > 2) frame_buf[2] = 8'(len >> 8);
    if (total > 3) frame_buf[3] = 8'(len);
    frame_buf[0] = ok_start ? start_code_now : start_code_now ^ 8'($urandom_range(1, 255));
    frame_buf[total-1] = ok_end ? end_code_now : end_code_now ^ 8'($urandom_range(1, 255));
    if (total > 7) begin
      covered = total;
      if (len + HEADER_EXTRA < covered) covered = len + HEADER_EXTRA;
      if (MAX_FRAME_BYTES < covered) covered = MAX_FRAME_BYTES;
      acc = CRC_INIT;
      for (int unsigned i = 0; i < covered; i++) begin
        acc = modbus_step(acc, (i == 5 || i == 6) ? 8'h00 : frame_buf[i]);
      end
      if (!ok_crc) acc ^= 16'($urandom_range(1, 65535));
      frame_buf[5] = acc[15:8];
      frame_buf[6] = acc[7:0];
    end
  endfunction

  // Mostly well-formed frames with random content so that most frames run the
  // whole header and CRC path; the rest are long, short, corrupt or pure noise.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned total;
    pick  = $urandom_range(99);
    len   = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(16);
    total = len + HEADER_EXTRA;
    if (pick < 55) begin
      build_frame(len, total, 1, 1, 1, -1);
    end else if (pick < 65) begin
      build_frame(len, total + $urandom_range(1, 6), 1, 1, 1, -1);
    end else if (pick < 73) begin
      build_frame(len, $urandom_range(1, total - 1), 1, 1, 1, -1);
    end else if (pick < 81) begin
      build_frame(len, total, 1, 1, 0, -1);
    end else if (pick < 87) begin
      build_frame(len, total, 1, 0, 1, -1);
    end else if (pick < 92) begin
      build_frame(len, total, 0, 1, 1, -1);
    end else begin
      build_frame($urandom_range(65535), $urandom_range(1, 24), $urandom_range(1),
                  $urandom_range(1), $urandom_range(1), -1);
    end
    send_frame();
  endtask

  // Every verdict and its precedence, field extremes, long and one-byte frames,
  // all under the reset values of the codes.
  task automatic test_verdict_cases();
    build_frame(0, 10, 1, 1, 1, -1);         send_frame();
    build_frame(5, 15, 1, 1, 1, 8'hFF);      send_frame();
    build_frame(3, 13, 1, 1, 1, 8'h00);      send_frame();
    build_frame(2, 12, 0, 0, 1, -1);         send_frame();
    build_frame(2, 12, 1, 0, 1, -1);         send_frame();
    build_frame(6, 9, 1, 0, 1, -1);          send_frame();
    build_frame(8, 12, 1, 1, 1, -1);         send_frame();
    build_frame(65535, 20, 1, 1, 1, 8'hFF);  send_frame();
    build_frame(4, 14, 1, 1, 0, -1);         send_frame();
    build_frame(9, 15, 1, 1, 0, -1);         send_frame();
    build_frame(2, 17, 1, 1, 1, -1);         send_frame();
    build_frame(1, 14, 1, 1, 0, -1);         send_frame();
    build_frame(0, 2, 1, 1, 1, -1);          send_frame();
    // A one-byte frame is checked as start and end at once.
    frame_buf.delete(); frame_buf.push_back(start_code_now); send_frame();
    frame_buf.delete(); frame_buf.push_back(end_code_now);   send_frame();
    settle();
  endtask

  // Both code registers at their extremes, then equal to each other.
  task automatic test_code_settings();
    write_code(CFG_START_CODE, 8'h00);
    write_code(CFG_END_CODE, 8'hFF);
    build_frame(0, 10, 1, 1, 1, 8'h00);
    send_frame();
    send_random_frame();
    write_code(CFG_START_CODE, 8'hFF);
    write_code(CFG_END_CODE, 8'h00);
    build_frame(7, 17, 1, 1, 1, 8'hFF);
    send_frame();
    send_random_frame();
    // With equal codes a one-byte frame passes both code checks and is short.
    write_code(CFG_START_CODE, 8'h3C);
    write_code(CFG_END_CODE, 8'h3C);
    frame_buf.delete(); frame_buf.push_back(8'h3C); send_frame();
    settle();
  endtask

  task automatic test_random_traffic();
    int first_byte_mark;
    for (int phase = 0; phase < 2; phase++) begin
      write_code(CFG_START_CODE, 8'($urandom));
      write_code(CFG_END_CODE, 8'($urandom));
      first_byte_mark = bytes_sent;
      for (int n = 0; n < 2 || bytes_sent - first_byte_mark < 25; n++) begin
        send_random_frame();
      end
    end
    write_code(CFG_START_CODE, START_CODE_RESET);
    write_code(CFG_END_CODE, END_CODE_RESET);
  endtask

  // A stretch with no idle cycles on either side.
  task automatic test_full_rate();
    calm = 1'b1;
    repeat (4) send_random_frame();
    settle();
    calm = 1'b0;
  endtask

  // The receiver holds off while one-byte and 11-byte frames keep coming: each
  // ends in a verdict, so the result register fills and the input has to stall.
  task automatic test_output_holdoff();
    hold_req = 400;
    repeat (4) begin
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      send_frame();
      build_frame(1, 11, 1, 1, 1, -1);
      send_frame();
    end
    settle();
  endtask

  // The sender stops until every verdict is out, then picks up again.
  task automatic test_drain_pause();
    send_random_frame();
    settle();
    send_random_frame();
    settle();
  endtask

  initial begin
    start_code_now = START_CODE_RESET;
    end_code_now   = END_CODE_RESET;
    clear_tracking();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_verdict_cases();
    test_code_settings();
    test_random_traffic();
    test_full_rate();
    test_output_holdoff();
    test_drain_pause();

    settle();
    repeat (8) @(posedge clk);
    $display("Summary: %0d frame bytes accepted; verdicts ok %0d, bad start %0d, bad end %0d,",
             bytes_accepted, verdict_seen[ST_OK], verdict_seen[ST_BAD_START],
             verdict_seen[ST_BAD_END]);
    $display("  short %0d, checksum %0d; %0d code writes, %0d input stall cycles, hold-off %0d.",
             verdict_seen[ST_SHORT], verdict_seen[ST_CRC], code_writes, stall_cycles,
             longest_hold);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
